// ===== hw/rtl/assert_macros.svh =====
// Assertion macros shared by the RTL files that carry checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that an expression holds at every rising clock edge out of reset.
`define ASSERT_HOLDS(label, clk, rst, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// Check that a condition implies another one in the next cycle.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hw/rtl/tppi_pkg.sv =====
// Shared types, constants and table function of the three-phase playback interpolator.
package tppi_pkg;

  localparam int QUEUE_DEPTH_DEF = 16;
  localparam int SINE_DEPTH_DEF  = 256;
  localparam int CUR_W           = 24;
  localparam int TIME_W          = 32;
  localparam int CFG_IDX_W       = 3;
  localparam int CFG_DATA_W      = 32;

  localparam logic [15:0] THIRD_TURN      = 16'd21845;
  localparam logic [15:0] LANE_OFFSET_A   = 16'd0;
  localparam logic [15:0] LANE_OFFSET_B   = 16'd43691;
  localparam logic [15:0] LANE_OFFSET_C   = 16'd21845;
  localparam logic [63:0] HALF_PI_Q30     = 64'd1686629713;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PLAYBACK_MODE = 3'd0,
    REG_SCALE_RECIP   = 3'd1,
    REG_AMPLITUDE     = 3'd2,
    REG_PHASE_OFFSET  = 3'd3,
    REG_PHASE_RATE    = 3'd4
  } cfg_reg_t;

  typedef enum logic [2:0] {
    L_IDLE, L_MUL, L_ABS, L_DIV, L_FIX, L_SCL, L_SAT, L_DONE
  } lane_st_t;

  typedef enum logic [2:0] {
    T_IDLE, T_READ, T_ADV, T_RUN, T_WAIT
  } top_st_t;

  // Command from the sequencer to every lane
  typedef struct packed {
    logic               start;
    logic               playback;
    logic               zero_gap;
    logic signed [32:0] dt;
    logic signed [32:0] gap;
    logic [15:0]        scale;
    logic [22:0]        amp;
    logic [15:0]        base_ang;
  } lane_cmd_t;

  // Result of one lane
  typedef struct packed {
    logic               done;
    logic               ovf;
    logic signed [23:0] value;
  } lane_res_t;

  // Quarter-wave sine in Q23 from a Q30 angle, by a Taylor series
  function automatic logic [23:0] sine_poly(input logic [63:0] x);
    logic [63:0]        x2;
    logic [63:0]        term;
    logic signed [64:0] s;
    logic [64:0]        r;
    x2   = (x * x) >> 30;
    term = x;
    s    = $signed({1'b0, x});
    for (int k = 1; k <= 7; k++) begin
      term = ((term * x2) >> 30) / 64'((2 * k) * (2 * k + 1));
      if ((k % 2) == 1) begin
        s = s - $signed({1'b0, term});
      end else begin
        s = s + $signed({1'b0, term});
      end
    end
    if (s < 0) begin
      s = '0;
    end
    r = $unsigned(s) + 65'd64;
    return r[30:7];
  endfunction

endpackage

// ===== hw/rtl/tppi_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
module tppi_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write on enable, read every cycle
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hw/rtl/tppi_lane.sv =====
// One phase lane: interpolation with iterative divide, or table sine, then scaling.
module tppi_lane #(
  parameter int          SINE_TABLE_DEPTH = 256,
  parameter logic [15:0] ANG_OFFSET       = 16'd0
) (
  input  logic                      clk,
  input  logic                      rst,
  input  tppi_pkg::lane_cmd_t       cmd,
  input  logic signed [23:0]        lower_cur,
  input  logic signed [23:0]        upper_cur,
  output tppi_pkg::lane_res_t       res
);
  import tppi_pkg::*;

  localparam int SW = $clog2(SINE_TABLE_DEPTH + 1);
  localparam logic [31:0] D1 = 32'(SINE_TABLE_DEPTH);
  localparam logic [31:0] D2 = 32'(2 * SINE_TABLE_DEPTH);
  localparam logic [31:0] D3 = 32'(3 * SINE_TABLE_DEPTH);
  localparam logic [31:0] POS_MUL = 32'(4 * SINE_TABLE_DEPTH);
  localparam logic [55:0] Q_LIMIT = 56'h200_0000_0000;
  localparam logic signed [43:0] V_MAX = 44'sh100_0000_0000;
  localparam logic signed [43:0] V_MIN = -44'sh100_0000_0000;
  localparam logic [4:0] DIV_LAST = 5'd27;

  // Constant quarter-wave table
  logic [23:0] sin_tab [SINE_TABLE_DEPTH + 1];
  for (genvar j = 0; j <= SINE_TABLE_DEPTH; j++) begin : g_tab
    localparam logic [63:0] X = (64'(j) * HALF_PI_Q30) / SINE_TABLE_DEPTH;
    assign sin_tab[j] = sine_poly(X);
  end

  lane_st_t st, st_next;

  logic signed [23:0] lo, hi;
  logic signed [32:0] dt_r, gap_r;
  logic [15:0]        scale_r, ang;
  logic [22:0]        amp_r;
  logic               play, zgap;
  logic signed [57:0] prod;
  logic               sign_q;
  logic [55:0]        num;
  logic [31:0]        den;
  logic [31:0]        rem;
  logic [4:0]         cnt;
  logic [1:0]         quad;
  logic [SW-1:0]      sidx;
  logic [23:0]        smag;
  logic               sneg;
  logic signed [41:0] v_r;
  logic signed [59:0] p_r;
  logic [46:0]        amp_prod;
  logic signed [23:0] value;
  logic               ovf;

  // Combinational helpers
  logic signed [57:0] diff_w, dt_w;
  logic [31:0]        posw;
  logic [31:0]        ipos;
  logic [1:0]         qd;
  logic [SW-1:0]      tidx;
  logic [32:0]        r1, r2;
  logic [31:0]        rem1, rem2;
  logic               b1, b2;
  logic [41:0]        q_sat;
  logic signed [43:0] q_sgn, v_sum, lo_w;
  logic signed [41:0] v_cl;
  logic signed [59:0] nv, p_w;
  logic signed [59:0] x_sh;
  logic [46:0]        rsum;
  logic [23:0]        rsh;

  always_comb begin
    diff_w = 58'(hi) - 58'(lo);
    dt_w   = 58'(dt_r);
    // Angle to quadrant and index
    posw = (32'(ang) * POS_MUL) >> 16;
    if (posw >= D3) begin
      qd = 2'd3; ipos = posw - D3;
    end else if (posw >= D2) begin
      qd = 2'd2; ipos = posw - D2;
    end else if (posw >= D1) begin
      qd = 2'd1; ipos = posw - D1;
    end else begin
      qd = 2'd0; ipos = posw;
    end
    tidx = quad[0] ? SW'(D1 - 32'(sidx)) : sidx;
    // Two restoring divide steps
    r1 = {rem, num[55]};
    b1 = (r1 >= {1'b0, den});
    rem1 = b1 ? 32'(r1 - {1'b0, den}) : r1[31:0];
    r2 = {rem1, num[54]};
    b2 = (r2 >= {1'b0, den});
    rem2 = b2 ? 32'(r2 - {1'b0, den}) : r2[31:0];
    // Quotient limit, add lower point, clamp
    q_sat = (num >= Q_LIMIT) ? Q_LIMIT[41:0] : num[41:0];
    q_sgn = sign_q ? -$signed({2'b00, q_sat}) : $signed({2'b00, q_sat});
    lo_w  = 44'(lo);
    v_sum = lo_w + q_sgn;
    if (zgap) begin
      v_cl = 42'(lo);
    end else if (v_sum > V_MAX) begin
      v_cl = 42'(V_MAX);
    end else if (v_sum < V_MIN) begin
      v_cl = 42'(V_MIN);
    end else begin
      v_cl = 42'(v_sum);
    end
    // Negate, scale and round
    nv   = -60'(v_r);
    p_w  = nv * $signed({44'd0, scale_r}) + 60'sd2048;
    x_sh = p_r >>> 12;
    rsum = amp_prod + 47'd4194304;
    rsh  = rsum[46:23];
  end

  // Next state
  always_comb begin
    st_next = st;
    unique case (st)
      L_IDLE, L_DONE: if (cmd.start) st_next = L_MUL;
      L_MUL:  st_next = L_ABS;
      L_ABS:  st_next = (play && !zgap) ? L_DIV : L_FIX;
      L_DIV:  if (cnt == DIV_LAST) st_next = L_FIX;
      L_FIX:  st_next = L_SCL;
      L_SCL:  st_next = play ? L_SAT : L_DONE;
      L_SAT:  st_next = L_DONE;
      default: st_next = L_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= L_IDLE;
    end else begin
      st <= st_next;
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    unique case (st)
      L_IDLE, L_DONE: begin
        if (cmd.start) begin
          lo      <= lower_cur;
          hi      <= upper_cur;
          dt_r    <= cmd.dt;
          gap_r   <= cmd.gap;
          scale_r <= cmd.scale;
          amp_r   <= cmd.amp;
          ang     <= cmd.base_ang + ANG_OFFSET;
          play    <= cmd.playback;
          zgap    <= cmd.zero_gap;
        end
      end
      L_MUL: begin
        prod <= dt_w * diff_w;
        quad <= qd;
        sidx <= SW'(ipos);
      end
      L_ABS: begin
        sign_q <= prod[57] ^ gap_r[32];
        num    <= prod[57] ? 56'(-prod) : prod[55:0];
        den    <= gap_r[32] ? 32'(-gap_r) : gap_r[31:0];
        rem    <= '0;
        cnt    <= '0;
        smag   <= sin_tab[tidx];
        sneg   <= quad[1];
      end
      L_DIV: begin
        rem <= rem2;
        num <= {num[53:0], b1, b2};
        cnt <= cnt + 5'd1;
      end
      L_FIX: begin
        v_r      <= v_cl;
        amp_prod <= 47'(amp_r) * 47'(smag);
      end
      L_SCL: begin
        p_r <= p_w;
        if (!play) begin
          value <= sneg ? -$signed(rsh) : $signed(rsh);
          ovf   <= 1'b0;
        end
      end
      L_SAT: begin
        if (x_sh > 60'sd8388607) begin
          value <= 24'sh7FFFFF;
          ovf   <= 1'b1;
        end else if (x_sh < -60'sd8388608) begin
          value <= -24'sh800000;
          ovf   <= 1'b1;
        end else begin
          value <= 24'(x_sh);
          ovf   <= 1'b0;
        end
      end
      default: begin
      end
    endcase
  end

  assign res.done  = (st == L_DONE);
  assign res.ovf   = ovf;
  assign res.value = value;

endmodule

// ===== hw/rtl/three_phase_playback_interpolator.sv =====
// Top level of the three-phase playback interpolator: queue, sequencer, lanes, output merge.
// Input channel (in_valid/in_stall): func 0 pushes a sample (time_req, sample_a..c),
// func 1 queries the three currents at time_req. Pushes give no result; each query
// gives one result item on the output channel (out_valid/out_stall).
// Configuration writes (cfg_valid/cfg_ready, cfg_index, cfg_data) are taken every
// cycle and must only be made while the block is idle.
// One item is worked at a time; in_stall stays high until it is finished.
// A push is accepted without raising in_stall. For an accepted playback query the pair
// first advances when needed (queue read in T_READ, then T_ADV), lane setup follows, then the
// three lanes in parallel run a 56-bit restoring divide at 2 quotient bits per cycle
// and scale/saturate. A zero time gap skips the divider; a sine-mode query uses the
// table sine and skips both the divider and the saturation step.
// The lanes' results merge into one output register; the next item is accepted
// while that result waits for the receiver.
// Reset clears the bracketing pair, queue pointers, configuration registers and the
// output valid; queue contents stay undefined until written.
// While out_stall is high a finished result holds the output register, and a
// following query waits in the sequencer until the register frees.
`include "assert_macros.svh"

module three_phase_playback_interpolator #(
  parameter int QUEUE_DEPTH      = tppi_pkg::QUEUE_DEPTH_DEF,
  parameter int SINE_TABLE_DEPTH = tppi_pkg::SINE_DEPTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [tppi_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [tppi_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic                             func,
  input  logic [tppi_pkg::TIME_W-1:0]      time_req,
  input  logic signed [tppi_pkg::CUR_W-1:0] sample_a,
  input  logic signed [tppi_pkg::CUR_W-1:0] sample_b,
  input  logic signed [tppi_pkg::CUR_W-1:0] sample_c,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic signed [tppi_pkg::CUR_W-1:0] current_a,
  output logic signed [tppi_pkg::CUR_W-1:0] current_b,
  output logic signed [tppi_pkg::CUR_W-1:0] current_c,
  output logic                             end_of_data,
  output logic                             range_flag
);
  import tppi_pkg::*;

  localparam int PW = $clog2(QUEUE_DEPTH);
  localparam int FW = $clog2(QUEUE_DEPTH + 1);
  localparam int RW = TIME_W + 3 * CUR_W;
  localparam logic [PW-1:0] PTR_LAST = PW'(QUEUE_DEPTH - 1);
  localparam logic [FW-1:0] FILL_MAX = FW'(QUEUE_DEPTH);

  // Configuration registers
  logic        playback_mode;
  logic [15:0] scale_recip;
  logic [22:0] amplitude;
  logic [15:0] phase_offset;
  logic [15:0] phase_rate;

  // Bracketing pair and queue control
  logic [TIME_W-1:0]       lower_time, upper_time;
  logic signed [CUR_W-1:0] lower_cur [3];
  logic signed [CUR_W-1:0] upper_cur [3];
  logic [1:0]              primed;
  logic [PW-1:0]           rd_ptr, wr_ptr;
  logic [FW-1:0]           fill;

  // Query context
  logic [TIME_W-1:0] t_q;
  logic [15:0]       base_ang;
  logic              play_q;
  logic              eod_q;

  top_st_t   state, state_next;
  lane_cmd_t cmd;
  lane_res_t res [3];

  logic          in_acc;
  logic          ram_we;
  logic [RW-1:0] ram_wdata, ram_rdata;
  logic          lanes_done;
  logic          slot_free;
  logic          out_load;
  logic          need_adv;
  logic          push_full;

  assign cfg_ready = 1'b1;
  assign in_stall  = (state != T_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign need_adv  = playback_mode && (upper_time < time_req);
  assign ram_we    = in_acc && !func && (primed == 2'd2) && (fill != FILL_MAX);
  assign push_full = in_acc && !func && (primed == 2'd2) && (fill == FILL_MAX);
  assign ram_wdata = {time_req, sample_a, sample_b, sample_c};
  assign lanes_done = res[0].done && res[1].done && res[2].done;
  assign slot_free  = !out_valid || !out_stall;
  assign out_load   = (state == T_WAIT) && lanes_done && slot_free;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      playback_mode <= 1'b1;
      scale_recip   <= 16'd4096;
      amplitude     <= '0;
      phase_offset  <= '0;
      phase_rate    <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_PLAYBACK_MODE: playback_mode <= cfg_data[0];
        REG_SCALE_RECIP:   scale_recip   <= cfg_data[15:0];
        REG_AMPLITUDE:     amplitude     <= cfg_data[22:0];
        REG_PHASE_OFFSET:  phase_offset  <= cfg_data[15:0];
        REG_PHASE_RATE:    phase_rate    <= cfg_data[15:0];
        default: begin
        end
      endcase
    end
  end

  // Sample queue storage
  tppi_ram #(
    .WIDTH(RW),
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk  (clk),
    .we   (ram_we),
    .waddr(wr_ptr),
    .wdata(ram_wdata),
    .raddr(rd_ptr),
    .rdata(ram_rdata)
  );

  // Sequencer next state
  always_comb begin
    state_next = state;
    unique case (state)
      T_IDLE: begin
        if (in_acc && func) begin
          state_next = (need_adv && (fill != '0)) ? T_READ : T_RUN;
        end
      end
      T_READ: state_next = T_ADV;
      T_ADV:  state_next = T_RUN;
      T_RUN:  state_next = T_WAIT;
      T_WAIT: if (out_load) state_next = T_IDLE;
      default: state_next = T_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= T_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Pair, queue pointers and query context
  always_ff @(posedge clk) begin
    if (rst) begin
      lower_time <= '0;
      upper_time <= '0;
      for (int k = 0; k < 3; k++) begin
        lower_cur[k] <= '0;
        upper_cur[k] <= '0;
      end
      primed <= '0;
      rd_ptr <= '0;
      wr_ptr <= '0;
      fill   <= '0;
      eod_q  <= 1'b0;
      play_q <= 1'b1;
    end else begin
      if (in_acc && !func) begin
        // Fill the pair first, then queue; drop when full
        if (primed == 2'd0) begin
          lower_time   <= time_req;
          lower_cur[0] <= sample_a;
          lower_cur[1] <= sample_b;
          lower_cur[2] <= sample_c;
          primed       <= 2'd1;
        end else if (primed == 2'd1) begin
          upper_time   <= time_req;
          upper_cur[0] <= sample_a;
          upper_cur[1] <= sample_b;
          upper_cur[2] <= sample_c;
          primed       <= 2'd2;
        end else if (fill != FILL_MAX) begin
          wr_ptr <= (wr_ptr == PTR_LAST) ? '0 : wr_ptr + 1'b1;
          fill   <= fill + 1'b1;
        end
      end
      if (in_acc && func) begin
        play_q <= playback_mode;
        eod_q  <= need_adv && (fill == '0);
      end
      // Advance the pair by one queued sample
      if (state == T_ADV) begin
        lower_time   <= upper_time;
        lower_cur[0] <= upper_cur[0];
        lower_cur[1] <= upper_cur[1];
        lower_cur[2] <= upper_cur[2];
        upper_time   <= ram_rdata[RW-1 -: TIME_W];
        upper_cur[0] <= ram_rdata[3*CUR_W-1 -: CUR_W];
        upper_cur[1] <= ram_rdata[2*CUR_W-1 -: CUR_W];
        upper_cur[2] <= ram_rdata[CUR_W-1 -: CUR_W];
        rd_ptr       <= (rd_ptr == PTR_LAST) ? '0 : rd_ptr + 1'b1;
        fill         <= fill - 1'b1;
      end
    end
  end

  // Query time and base angle
  always_ff @(posedge clk) begin
    if (in_acc && func) begin
      t_q      <= time_req;
      base_ang <= phase_offset + 16'(time_req[15:0] * phase_rate);
    end
  end

  // Lane command
  always_comb begin
    cmd.start    = (state == T_RUN);
    cmd.playback = play_q;
    cmd.gap      = $signed({1'b0, upper_time}) - $signed({1'b0, lower_time});
    cmd.dt       = $signed({1'b0, t_q}) - $signed({1'b0, lower_time});
    cmd.zero_gap = (upper_time == lower_time);
    cmd.scale    = scale_recip;
    cmd.amp      = amplitude;
    cmd.base_ang = base_ang;
  end

  tppi_lane #(.SINE_TABLE_DEPTH(SINE_TABLE_DEPTH), .ANG_OFFSET(LANE_OFFSET_A)) u_lane_a (
    .clk(clk), .rst(rst), .cmd(cmd),
    .lower_cur(lower_cur[0]), .upper_cur(upper_cur[0]), .res(res[0])
  );

  tppi_lane #(.SINE_TABLE_DEPTH(SINE_TABLE_DEPTH), .ANG_OFFSET(LANE_OFFSET_B)) u_lane_b (
    .clk(clk), .rst(rst), .cmd(cmd),
    .lower_cur(lower_cur[1]), .upper_cur(upper_cur[1]), .res(res[1])
  );

  tppi_lane #(.SINE_TABLE_DEPTH(SINE_TABLE_DEPTH), .ANG_OFFSET(LANE_OFFSET_C)) u_lane_c (
    .clk(clk), .rst(rst), .cmd(cmd),
    .lower_cur(lower_cur[2]), .upper_cur(upper_cur[2]), .res(res[2])
  );

  // Merge lane results into the output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      current_a   <= res[0].value;
      current_b   <= res[1].value;
      current_c   <= res[2].value;
      end_of_data <= play_q && eod_q;
      range_flag  <= play_q && (res[0].ovf || res[1].ovf || res[2].ovf || cmd.zero_gap);
    end
  end

  // Checks
  `ASSERT_HOLDS(a_fill_bound, clk, rst, fill <= FILL_MAX, "queue fill above depth")
  `ASSERT_NEXT(a_read_then_adv, clk, rst, state == T_READ, state == T_ADV, "advance skipped")
  `ASSERT_NEXT(a_full_drop, clk, rst, push_full, fill == FILL_MAX, "full queue fill changed")
  `ASSERT_NEXT(a_sine_flags, clk, rst, out_load && !play_q, !end_of_data && !range_flag, "sine flags")

endmodule

// ===== tb/sv/tppi_checker.sv =====
// Checker for the three-phase playback interpolator: predicts and compares each result.
module tppi_checker (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_valid,
  input  logic                             cfg_ready,
  input  logic [tppi_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [tppi_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                             in_valid,
  input  logic                             in_stall,
  input  logic                             func,
  input  logic [tppi_pkg::TIME_W-1:0]      time_req,
  input  logic signed [tppi_pkg::CUR_W-1:0] sample_a,
  input  logic signed [tppi_pkg::CUR_W-1:0] sample_b,
  input  logic signed [tppi_pkg::CUR_W-1:0] sample_c,
  input  logic                             out_valid,
  input  logic                             out_stall,
  input  logic signed [tppi_pkg::CUR_W-1:0] current_a,
  input  logic signed [tppi_pkg::CUR_W-1:0] current_b,
  input  logic signed [tppi_pkg::CUR_W-1:0] current_c,
  input  logic                             end_of_data,
  input  logic                             range_flag,
  output int                               fail_count,
  output int                               pending,
  output int                               result_count
);
  import tppi_pkg::*;

  localparam int QDEPTH = QUEUE_DEPTH_DEF;
  localparam int TDEPTH = SINE_DEPTH_DEF;

  typedef struct {
    logic signed [23:0] cur [3];
    logic               eod;
    logic               flag;
  } currents_t;

  currents_t expected_currents [$];

  // Mirror of configuration and pair/queue state
  logic        mode_play;
  logic [15:0] recip;
  logic [22:0] amp;
  logic [15:0] ph_off;
  logic [15:0] ph_rate;
  logic [31:0] lo_t, up_t;
  logic signed [23:0] lo_c [3];
  logic signed [23:0] up_c [3];
  int          primed;
  logic [31:0] fifo_t [QDEPTH];
  logic signed [23:0] fifo_c [QDEPTH][3];
  int          rd_ptr, wr_ptr, fill;
  logic [23:0] quarter [TDEPTH+1];

  function automatic logic [23:0] quarter_wave(input int j);
    longint unsigned x, x2, term;
    longint          s;
    x    = (longint'(j) * 64'd1686629713) / TDEPTH;
    x2   = (x * x) >> 30;
    term = x;
    s    = longint'(x);
    for (int k = 1; k <= 7; k++) begin
      term = ((term * x2) >> 30) / longint'((2 * k) * (2 * k + 1));
      if (k % 2 == 1) s = s - longint'(term);
      else s = s + longint'(term);
    end
    if (s < 0) s = 0;
    return 24'((s + 64) >>> 7);
  endfunction

  function automatic longint sine_of(input logic [15:0] ang);
    int  pos, q, i, idx;
    longint v;
    pos = (int'(ang) * 4 * TDEPTH) >> 16;
    q   = (pos / TDEPTH) % 4;
    i   = pos % TDEPTH;
    idx = (q % 2 == 1) ? TDEPTH - i : i;
    v   = longint'(quarter[idx]);
    return (q >= 2) ? -v : v;
  endfunction

  function automatic longint floor_q12(input longint x);
    if (x >= 0) return x / 4096;
    return -((-x + 4095) / 4096);
  endfunction

  // Work out the result of one query, or absorb one sample
  task automatic predict_currents(input logic f, input logic [31:0] t,
                                  input logic signed [23:0] smp [3]);
    currents_t r;
    logic [15:0] base, ang;
    longint s, mag, m, gap, dt, v, diff, x;
    if (!f) begin
      if (primed == 0) begin
        lo_t = t; lo_c = smp; primed = 1;
      end else if (primed == 1) begin
        up_t = t; up_c = smp; primed = 2;
      end else if (fill < QDEPTH) begin
        fifo_t[wr_ptr] = t; fifo_c[wr_ptr] = smp;
        wr_ptr = (wr_ptr + 1) % QDEPTH; fill++;
      end
      return;
    end
    r.eod = 1'b0; r.flag = 1'b0;
    if (!mode_play) begin
      base = 16'(ph_off + ph_rate * t);
      for (int k = 0; k < 3; k++) begin
        ang = (k == 0) ? base : (k == 1) ? 16'(base - THIRD_TURN) : 16'(base + THIRD_TURN);
        s   = sine_of(ang);
        mag = (s < 0) ? -s : s;
        m   = (longint'(amp) * mag + 64'd4194304) >>> 23;
        r.cur[k] = 24'((s < 0) ? -m : m);
      end
    end else begin
      if (up_t < t) begin
        if (fill > 0) begin
          lo_t = up_t; lo_c = up_c;
          up_t = fifo_t[rd_ptr]; up_c = fifo_c[rd_ptr];
          rd_ptr = (rd_ptr + 1) % QDEPTH; fill--;
        end else begin
          r.eod = 1'b1;
        end
      end
      gap = $signed({32'd0, up_t}) - $signed({32'd0, lo_t});
      dt  = $signed({32'd0, t}) - $signed({32'd0, lo_t});
      if (gap == 0) r.flag = 1'b1;
      for (int k = 0; k < 3; k++) begin
        v = longint'(lo_c[k]);
        if (gap != 0) begin
          diff = longint'(up_c[k]) - longint'(lo_c[k]);
          v = v + (dt * diff) / gap;
        end
        if (v > (64'sd1 <<< 40)) v = 64'sd1 <<< 40;
        if (v < -(64'sd1 <<< 40)) v = -(64'sd1 <<< 40);
        x = floor_q12(-v * longint'(recip) + 2048);
        if (x > 8388607) begin x = 8388607; r.flag = 1'b1; end
        if (x < -8388608) begin x = -8388608; r.flag = 1'b1; end
        r.cur[k] = 24'(x);
      end
    end
    expected_currents.push_back(r);
  endtask

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("tppi_checker: result %0d %s mismatch: got %0h expected %0h",
             result_count, what, got, want);
    fail_count++;
  endtask

  initial begin
    for (int j = 0; j <= TDEPTH; j++) quarter[j] = quarter_wave(j);
    fail_count = 0;
    result_count = 0;
  end

  assign pending = expected_currents.size();

  // Follow every handshake at the rising edge
  always @(posedge clk) begin
    currents_t w;
    logic signed [23:0] smp [3];
    if (rst) begin
      mode_play = 1'b1; recip = 16'd4096; amp = '0; ph_off = '0; ph_rate = '0;
      lo_t = '0; up_t = '0; primed = 0; rd_ptr = 0; wr_ptr = 0; fill = 0;
      for (int k = 0; k < 3; k++) begin lo_c[k] = '0; up_c[k] = '0; end
      expected_currents.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_reg_t'(cfg_index))
          REG_PLAYBACK_MODE: mode_play = cfg_data[0];
          REG_SCALE_RECIP:   recip     = cfg_data[15:0];
          REG_AMPLITUDE:     amp       = cfg_data[22:0];
          REG_PHASE_OFFSET:  ph_off    = cfg_data[15:0];
          REG_PHASE_RATE:    ph_rate   = cfg_data[15:0];
          default: ;
        endcase
      end
      if (out_valid && !out_stall) begin
        if (expected_currents.size() == 0) begin
          $display("tppi_checker: result with no query waiting");
          fail_count++;
        end else begin
          w = expected_currents.pop_front();
          if (current_a !== w.cur[0]) report_mismatch("current_a", current_a, w.cur[0]);
          if (current_b !== w.cur[1]) report_mismatch("current_b", current_b, w.cur[1]);
          if (current_c !== w.cur[2]) report_mismatch("current_c", current_c, w.cur[2]);
          if (end_of_data !== w.eod) report_mismatch("end_of_data", end_of_data, w.eod);
          if (range_flag !== w.flag) report_mismatch("range_flag", range_flag, w.flag);
        end
        result_count++;
      end
      if (in_valid && !in_stall) begin
        smp[0] = sample_a; smp[1] = sample_b; smp[2] = sample_c;
        predict_currents(func, time_req, smp);
      end
    end
  end
endmodule

// ===== tb/sv/tb_top.sv =====
// Testbench top of the three-phase playback interpolator: stimulus, watchdog and verdict.
module tb_top;
  import tppi_pkg::*;

  localparam int WATCHDOG_LIMIT = 5000;

  logic clk, rst;
  logic cfg_valid, cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  logic in_valid, in_stall, func;
  logic [TIME_W-1:0] time_req;
  logic signed [CUR_W-1:0] sample_a, sample_b, sample_c;
  logic out_valid, out_stall;
  logic signed [CUR_W-1:0] current_a, current_b, current_c;
  logic end_of_data, range_flag;
  int   fail_count, pending, result_count;
  int   idle_cycles, item_count;
  logic no_idle;
  logic [31:0] push_t, query_t;

  three_phase_playback_interpolator DUT (.*);

  tppi_checker checker_i (.*);

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Drop the run when nothing moves for too long
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("tb_top: watchdog expired with %0d results outstanding", pending);
      $display("tb_top: FAIL");
      $finish;
    end
  end

  // Stall the result side for a random count after each result
  initial begin
    int n;
    out_stall = 1'b1;
    @(negedge clk);
    forever begin
      n = no_idle ? 0 : $urandom_range(0, 6);
      out_stall = (n > 0);
      repeat (n) @(negedge clk);
      out_stall = 1'b0;
      do @(posedge clk); while (!out_valid);
      @(negedge clk);
    end
  end

  task automatic send_item(input logic f, input logic [31:0] t, input logic [23:0] a,
                           input logic [23:0] b, input logic [23:0] c);
    int n;
    n = no_idle ? 0 : $urandom_range(0, 6);
    if (n > 0) begin
      in_valid = 1'b0;
      repeat (n) @(negedge clk);
    end
    func = f; time_req = t; sample_a = a; sample_b = b; sample_c = c;
    in_valid = 1'b1;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
    item_count++;
  endtask

  task automatic push_sample(input logic [31:0] t);
    send_item(1'b0, t, $urandom, $urandom, $urandom);
  endtask

  task automatic query_at(input logic [31:0] t);
    send_item(1'b1, t, $urandom, $urandom, $urandom);
  endtask

  // Wait for all results and for the block to drain before a register write
  task automatic settle();
    in_valid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (60) @(negedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [31:0] data);
    cfg_index = idx; cfg_data = data; cfg_valid = 1'b1;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic write_all(input logic m, input logic [15:0] sc, input logic [22:0] am,
                           input logic [15:0] off, input logic [15:0] rate);
    write_reg(REG_PLAYBACK_MODE, {31'd0, m});
    write_reg(REG_SCALE_RECIP, {16'd0, sc});
    write_reg(REG_AMPLITUDE, {9'd0, am});
    write_reg(REG_PHASE_OFFSET, {16'd0, off});
    write_reg(REG_PHASE_RATE, {16'd0, rate});
  endtask

  function automatic logic [15:0] pick16();
    case ($urandom_range(0, 2))
      0: return 16'd0;
      1: return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  initial begin
    logic [22:0] am;
    logic [15:0] sc;
    int r;
    rst = 1'b1; cfg_valid = 1'b0; cfg_index = '0; cfg_data = '0;
    in_valid = 1'b0; func = 1'b0; time_req = '0;
    sample_a = '0; sample_b = '0; sample_c = '0;
    no_idle = 1'b0; idle_cycles = 0; item_count = 0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed: unprimed pair, zero gap, out-of-order samples, empty queue
    query_at(32'd0);
    send_item(1'b0, 32'd100, 24'h7FFFFF, 24'h800000, 24'h000000);
    query_at(32'd50);
    send_item(1'b0, 32'd100, 24'h000001, 24'hFFFFFF, 24'h7FFFFF);
    query_at(32'd100);
    send_item(1'b0, 32'd300, 24'h800000, 24'h7FFFFF, 24'h123456);
    send_item(1'b0, 32'd200, 24'h400000, 24'hC00000, 24'h000000);
    push_sample(32'hFFFFFFFF);
    query_at(32'd150);
    query_at(32'd250);
    query_at(32'd400);
    query_at(32'hFFFFFFFF);
    query_at(32'hFFFFFFFF);
    // Fill the queue past its depth so the extra samples drop
    for (int k = 0; k < 18; k++) push_sample(32'hFFFFFFFF);
    query_at(32'd0);
    settle();
    write_all(1'b1, 16'hFFFF, 23'd0, 16'd0, 16'd0);
    query_at(32'd7);
    settle();
    write_all(1'b0, 16'd0, 23'h7FFFFF, 16'hFFFF, 16'hFFFF);
    query_at(32'd0);
    query_at(32'hFFFFFFFF);
    push_sample(32'd5);
    query_at(32'd12345);
    settle();

    // Random phases, each with its own register setting
    push_t = 32'd1000;
    query_t = 32'd1000;
    for (int p = 0; p < 8; p++) begin
      no_idle = (p == 2);
      sc = (p == 0) ? 16'd0 : (p == 1) ? 16'hFFFF : (p % 2 == 0) ? 16'd4096 : pick16();
      am = (p == 4) ? 23'h7FFFFF : (p == 6) ? 23'd0 : 23'($urandom);
      write_all((p % 4) != 3, sc, am, pick16(), pick16());
      for (int n = 0; n < 50; n++) begin
        r = $urandom_range(0, 99);
        if (r < 10) begin
          send_item(1'($urandom), $urandom, $urandom, $urandom, $urandom);
        end else if (r < 50) begin
          push_t = push_t + $urandom_range(0, 40);
          push_sample(push_t);
        end else begin
          query_t = query_t + $urandom_range(0, 25);
          query_at(query_t);
        end
      end
      settle();
    end
    no_idle = 1'b0;
    settle();

    $display("tb_top: %0d items sent, %0d results checked over 8 register settings",
             item_count, result_count);
    $display("tb_top: covered playback, sinusoid, zero gap, empty and full queue");
    if (fail_count == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end
endmodule

// ===== three_phase_playback_interpolator.f =====
+incdir+hw/rtl
hw/rtl/tppi_pkg.sv
hw/rtl/tppi_ram.sv
hw/rtl/tppi_lane.sv
hw/rtl/three_phase_playback_interpolator.sv
tb/sv/tppi_checker.sv
tb/sv/tb_top.sv
